// File: rtl/core/bmp_pixel_unpacker_defines.svh
// Assertion macros shared by the bmp_pixel_unpacker RTL.
// No dependencies; include by bare file name.
`ifndef BMP_PIXEL_UNPACKER_DEFINES_SVH
`define BMP_PIXEL_UNPACKER_DEFINES_SVH

// Implication in the same cycle, disabled during reset.
`define BPU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpu assertion failed");

// Implication into the next cycle, disabled during reset.
`define BPU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpu assertion failed");

`endif

// File: rtl/core/bpu_pkg.sv
// Shared constants and types for the BMP pixel unpacker.
// Used by bpu_palette and bmp_pixel_unpacker; no dependencies.
package bpu_pkg;

  localparam int DEF_MAX_WIDTH     = 4096;
  localparam int DEF_MAX_HEIGHT    = 4096;
  localparam int DEF_PALETTE_DEPTH = 256;

  localparam int COLOR_W = 24;
  localparam int SLOT_W  = 8;
  localparam int PADDR_W = 4;
  localparam int PIXA_W  = 24;

  // depth_code values
  localparam logic [1:0] DEPTH_1BPP  = 2'd0;
  localparam logic [1:0] DEPTH_4BPP  = 2'd1;
  localparam logic [1:0] DEPTH_8BPP  = 2'd2;
  localparam logic [1:0] DEPTH_32BPP = 2'd3;

  // register indexes
  localparam logic [1:0] REG_DEPTH  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_ZALPHA = 2'd3;

  // input op codes
  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_PIXEL   = 1'b1;

  typedef struct packed {
    logic                en;
    logic [SLOT_W-1:0]   slot;
    logic [COLOR_W-1:0]  color;
  } pal_wr_t;

  typedef struct packed {
    logic                en;
    logic [SLOT_W-1:0]   slot;
  } pal_rd_t;

endpackage

// File: rtl/core/bpu_palette.sv
// Palette memory: PALETTE_DEPTH x 24-bit colors, one write and one read port.
// Read data is registered and holds until the next read. Depends on bpu_pkg.
module bpu_palette
  import bpu_pkg::*;
#(
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
  input  logic               clk,
  input  pal_wr_t            wr,
  input  pal_rd_t            rd,
  output logic [COLOR_W-1:0] rdata
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [COLOR_W-1:0] mem [PALETTE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.slot[AW-1:0]] <= wr.color;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata <= mem[rd.slot[AW-1:0]];
    end
  end

endmodule

// File: rtl/core/bmp_pixel_unpacker.sv
// Pipeline: an accepted pixel word fills the generator; each pixel then passes the palette
// read stage and the output register. Throughput: one pixel per cycle from a single pixel
// generator while out_stall is low; in_stall holds while a word is unpacked (32 pixels at
// 1 bpp, 8, 4, 1 at 32 bpp); palette writes and words past the image end never hold it.
// Reset: registers to defaults (32 bpp, 1x1, zero_alpha off), position and done cleared;
// palette contents stay undefined until written, no clearing pass.
module bmp_pixel_unpacker
  import bpu_pkg::*;
#(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [31:0]        in_data_word,
  input  logic [SLOT_W-1:0]  in_palette_slot,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_alpha,
  output logic [PIXA_W-1:0]  out_pixel_address,
  output logic               out_last_of_word,
  output logic               out_last_of_image,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

`include "bmp_pixel_unpacker_defines.svh"

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = WW + HW;

  typedef struct packed {
    logic              direct;
    logic              transp;
    logic              oob;
    logic [31:0]       word;
    logic [PIXA_W-1:0] addr;
    logic              low;
    logic              loi;
  } pix_meta_t;

  // configuration registers
  logic [1:0]  depth_r;
  logic [12:0] width_r;
  logic [12:0] height_r;
  logic        zalpha_r;

  // generator state
  logic              gen_r, gen_nxt;
  logic [31:0]       word_r, word_nxt;
  logic [4:0]        k_r, k_nxt;
  logic [5:0]        count_r, count_nxt;
  logic [WW-1:0]     col_r, col_nxt;
  logic [HW-1:0]     row_r, row_nxt;
  logic              done_r, done_nxt;
  logic [PIXA_W-1:0] base_r, base_nxt;

  // read stage and output register
  logic              s1_valid_r;
  pix_meta_t         s1_r;
  logic              out_valid_r;

  logic [WW-1:0]     width_eff;
  logic [HW-1:0]     height_eff;
  logic [WW-1:0]     remaining;
  logic [5:0]        per_word;
  logic [5:0]        count_new;
  logic [PW-1:0]     prod;
  logic [7:0]        idx;
  logic              in_acc, cfg_wr, issue, s1_move, out_acc, last_k, last_img;
  logic [COLOR_W-1:0] pal_rdata;
  pal_wr_t           pal_wr;
  pal_rd_t           pal_rd;
  pix_meta_t         meta;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      REG_DEPTH:  prdata = {30'd0, depth_r};
      REG_WIDTH:  prdata = {19'd0, width_r};
      REG_HEIGHT: prdata = {19'd0, height_r};
      REG_ZALPHA: prdata = {31'd0, zalpha_r};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= DEPTH_32BPP;
      width_r  <= 13'd1;
      height_r <= 13'd1;
      zalpha_r <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_DEPTH:  depth_r  <= pwdata[1:0];
        REG_WIDTH:  width_r  <= pwdata[12:0];
        REG_HEIGHT: height_r <= pwdata[12:0];
        REG_ZALPHA: zalpha_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize saturates to the maximum
  always_comb begin
    if (width_r == 13'd0) begin
      width_eff = WW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(width_r);
    end
    if (height_r == 13'd0) begin
      height_eff = HW'(1);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      height_eff = HW'(MAX_HEIGHT);
    end else begin
      height_eff = HW'(height_r);
    end
  end

  always_comb begin
    case (depth_r)
      DEPTH_1BPP:  per_word = 6'd32;
      DEPTH_4BPP:  per_word = 6'd8;
      DEPTH_8BPP:  per_word = 6'd4;
      default:     per_word = 6'd1;
    endcase
  end

  assign remaining = width_eff - col_r;
  assign count_new = (32'(remaining) < 32'(per_word)) ? 6'(remaining) : per_word;
  assign prod      = PW'(height_eff - HW'(1) - row_r) * PW'(width_eff);

  assign in_stall = gen_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign issue    = gen_r && (!s1_valid_r || s1_move);
  assign last_k   = (6'(k_r) == count_r - 6'd1);
  assign last_img = (row_r == height_eff - HW'(1)) && (col_r == width_eff - WW'(1));

  // palette index of pixel k, MSB-first within each byte
  always_comb begin
    case (depth_r)
      DEPTH_1BPP: idx = {7'd0, word_r[{k_r[4:3], ~k_r[2:0]}]};
      DEPTH_4BPP: idx = {4'd0, word_r[{k_r[2:1], ~k_r[0], 2'b00} +: 4]};
      DEPTH_8BPP: idx = word_r[{k_r[1:0], 3'b000} +: 8];
      default:    idx = 8'd0;
    endcase
  end

  always_comb begin
    meta.direct = (depth_r == DEPTH_32BPP);
    meta.transp = zalpha_r && (meta.direct ? (word_r == 32'hFF00_0000) : (idx == 8'd0));
    meta.oob    = ({1'b0, idx} >= 9'(PALETTE_DEPTH));
    meta.word   = word_r;
    meta.addr   = base_r + PIXA_W'(col_r);
    meta.low    = last_k;
    meta.loi    = last_img;
  end

  assign pal_wr.en    = in_acc && (in_op == OP_PALETTE) &&
                        ({1'b0, in_palette_slot} < 9'(PALETTE_DEPTH));
  assign pal_wr.slot  = in_palette_slot;
  assign pal_wr.color = in_data_word[COLOR_W-1:0];
  assign pal_rd.en    = issue && !meta.direct;
  assign pal_rd.slot  = idx;

  bpu_palette #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .wr    (pal_wr),
    .rd    (pal_rd),
    .rdata (pal_rdata)
  );

  always_comb begin
    gen_nxt   = gen_r;
    word_nxt  = word_r;
    k_nxt     = k_r;
    count_nxt = count_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    done_nxt  = done_r;
    base_nxt  = base_r;
    if (cfg_wr && (paddr[3:2] != REG_ZALPHA)) begin
      // geometry change restarts the image
      col_nxt  = '0;
      row_nxt  = '0;
      done_nxt = 1'b0;
    end else if (in_acc) begin
      // drop data transactions after the image end
      if ((in_op == OP_PIXEL) && !done_r) begin
        gen_nxt   = 1'b1;
        word_nxt  = in_data_word;
        k_nxt     = 5'd0;
        count_nxt = count_new;
        base_nxt  = PIXA_W'(prod);
      end
    end else if (issue) begin
      k_nxt   = k_r + 5'd1;
      col_nxt = col_r + WW'(1);
      if (last_img) begin
        done_nxt = 1'b1;
      end
      if (last_k) begin
        gen_nxt = 1'b0;
        if (col_r + WW'(1) == width_eff) begin
          col_nxt = '0;
          if (!last_img) begin
            row_nxt = row_r + HW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r  <= 1'b0;
      col_r  <= '0;
      row_r  <= '0;
      done_r <= 1'b0;
      k_r    <= '0;
      count_r <= '0;
    end else begin
      gen_r   <= gen_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      done_r  <= done_nxt;
      k_r     <= k_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    base_r <= base_nxt;
  end

  // read stage: hold while the output register is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (issue) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_r <= meta;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      if (s1_r.direct) begin
        out_red   <= s1_r.word[23:16];
        out_green <= s1_r.word[15:8];
        out_blue  <= s1_r.word[7:0];
        out_alpha <= s1_r.transp ? 8'd0 : s1_r.word[31:24];
      end else begin
        out_red   <= s1_r.oob ? 8'd0 : pal_rdata[23:16];
        out_green <= s1_r.oob ? 8'd0 : pal_rdata[15:8];
        out_blue  <= s1_r.oob ? 8'd0 : pal_rdata[7:0];
        out_alpha <= s1_r.transp ? 8'd0 : 8'd255;
      end
      out_pixel_address <= s1_r.addr;
      out_last_of_word  <= s1_r.low;
      out_last_of_image <= s1_r.loi;
    end
  end

  assign out_valid = out_valid_r;

  `BPU_ASSERT_IMP(a_s1_no_overwrite, clk, rst_n, s1_valid_r && !s1_move, !issue)
  `BPU_ASSERT_IMP(a_done_idle, clk, rst_n, done_r, !gen_r)
  `BPU_ASSERT_IMP(a_k_in_range, clk, rst_n, gen_r, 6'(k_r) < count_r)
  `BPU_ASSERT_IMP(a_pos_in_range, clk, rst_n, 1'b1, (col_r < width_eff) && (row_r < height_eff))
  `BPU_ASSERT_NXT(a_last_ends_word, clk, rst_n, issue && last_k, !gen_r)

endmodule
